// File: rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit
// Operation codes, status codes and the controller/datapath command types.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int DefValueWidth = 32;

  typedef enum logic [2:0] {
    OP_NORM = 3'd0,
    OP_NEG  = 3'd1,
    OP_ADD  = 3'd2,
    OP_SUB  = 3'd3,
    OP_MUL  = 3'd4,
    OP_DIV  = 3'd5,
    OP_LESS = 3'd6,
    OP_RSVD = 3'd7
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture operands
    logic mul;       // one cross-product step
    logic combine;   // form raw numerator and denominator
    logic gcd_init;  // set up gcd operands
    logic gcd_step;  // one binary gcd step
    logic div_init;  // set up exact division
    logic div_step;  // one restoring division bit
    logic finish;    // form the result
  } rau_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic mul_done;
    logic special;   // zero denominator, zero numerator or compare
    logic gcd_done;
    logic div_done;
  } rau_stat_t;

endpackage

// File: rtl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: exact arithmetic on two rationals
// Normalize, negate, add, subtract, multiply, divide and compare with gcd
// reduction.
// ----------------------------------------------------------------------------
// Usage: drive kind and the four operand ports and raise start while busy is
// low; the item is taken at that edge and busy stays high until the cycle in
// which the result is shown. The result appears on res_num, res_den, is_less
// and status, marked by done, which is high for a single cycle; the outputs
// then hold until the next result, and the receiver cannot stall. After the
// accepting edge the sequencer forms the four cross products on a shared
// multiplier (one 32x32 product per cycle), then the combine step, the gcd
// setup step, then the binary gcd on the 65-bit raw values (stripping common
// twos, then shifts and subtractions until y is zero and a step to see the
// end), then bit-serial exact division of both values at once, then the
// finish step; done is high in the cycle after it. Compares and results with
// a zero numerator or denominator skip gcd and division. One item at a time;
// the next may be taken at the edge that ends the done cycle. Reset returns
// the sequencer to idle and drops any item in work.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int VALUE_WIDTH = DefValueWidth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic [2:0]  kind,
  input  logic [31:0] a_num,
  input  logic [31:0] a_den,
  input  logic [31:0] b_num,
  input  logic [31:0] b_den,
  output logic [31:0] res_num,
  output logic [30:0] res_den,
  output logic        is_less,
  output logic [1:0]  status
);

  rau_cmd_t  cmd;
  rau_stat_t stat;

  rau_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .done (done),
    .cmd  (cmd),
    .stat (stat)
  );

  rau_dp #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dp (
    .clk    (clk),
    .cmd    (cmd),
    .stat   (stat),
    .kind   (kind),
    .a_num  (a_num),
    .a_den  (a_den),
    .b_num  (b_num),
    .b_den  (b_den),
    .res_num(res_num),
    .res_den(res_den),
    .is_less(is_less),
    .status (status)
  );

endmodule

// File: rtl/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl: sequencer of the rational arithmetic unit
// Steps the datapath through multiply, gcd, division and finish phases.
// ----------------------------------------------------------------------------
module rau_ctrl
  import rau_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  output logic      done,
  output rau_cmd_t  cmd,
  input  rau_stat_t stat
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_COMB, S_GCDI, S_GCD, S_DIV, S_FIN
  } state_t;

  state_t state;

  // command decode
  always_comb begin
    cmd          = '0;
    cmd.load     = (state == S_IDLE) && start;
    cmd.mul      = (state == S_MUL);
    cmd.combine  = (state == S_COMB);
    cmd.gcd_init = (state == S_GCDI);
    cmd.gcd_step = (state == S_GCD);
    cmd.div_init = (state == S_GCD) && stat.gcd_done;
    cmd.div_step = (state == S_DIV);
    cmd.finish   = (state == S_FIN);
  end

  assign busy = (state != S_IDLE);

  // state and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: if (start) state <= S_MUL;
        S_MUL:  if (stat.mul_done) state <= S_COMB;
        S_COMB: state <= S_GCDI;
        S_GCDI: state <= stat.special ? S_FIN : S_GCD;
        S_GCD:  if (stat.gcd_done) state <= S_DIV;
        S_DIV:  if (stat.div_done) state <= S_FIN;
        S_FIN: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/rau_dp.sv
// ----------------------------------------------------------------------------
// rau_dp: datapath of the rational arithmetic unit
// Sign-magnitude cross products, binary gcd and two exact bit-serial divides.
// ----------------------------------------------------------------------------
module rau_dp
  import rau_pkg::*;
#(
  parameter int VALUE_WIDTH = DefValueWidth
) (
  input  logic                   clk,
  input  rau_cmd_t               cmd,
  output rau_stat_t              stat,
  input  logic [2:0]             kind,
  input  logic [31:0]            a_num,
  input  logic [31:0]            a_den,
  input  logic [31:0]            b_num,
  input  logic [31:0]            b_den,
  output logic [31:0]            res_num,
  output logic [30:0]            res_den,
  output logic                   is_less,
  output logic [1:0]             status
);

  localparam int W  = VALUE_WIDTH;
  localparam int PW = 2 * W + 1;         // products and their sum
  localparam int CW = $clog2(PW + 1);

  // operand magnitudes and signs
  op_t           op;
  logic          ans, ads, bns, bds;
  logic [W-1:0]  anm, adm, bnm, bdm;
  logic          ad_zero, bd_zero;

  function automatic logic [W-1:0] magw(input logic [W-1:0] v);
    magw = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  // products computed one per cycle on a shared multiplier
  logic [1:0]      mcnt;
  logic [2*W-1:0]  p_anbd, p_adbn, p_anbn, p_adbd;
  logic [W-1:0]    mx, my;
  logic [2*W-1:0]  mprod;

  always_comb begin
    case (mcnt)
      2'd0:    begin mx = anm; my = bdm; end
      2'd1:    begin mx = adm; my = bnm; end
      2'd2:    begin mx = anm; my = bnm; end
      default: begin mx = adm; my = bdm; end
    endcase
  end
  assign mprod = mx * my;
  assign stat.mul_done = (mcnt == 2'd3);

  // raw result in sign-magnitude form
  logic          ns, ds, cmp_op, lt;
  logic [PW-1:0] nm, dm;

  // gcd and division registers
  logic [PW-1:0] gx, gy;
  logic [CW-1:0] gk;
  logic          g_odd;
  logic [PW-1:0] dvs, q_n, q_d, r_n, r_d;
  logic [CW-1:0] dcnt;

  assign stat.special  = cmp_op || (dm == '0) || (nm == '0);
  assign stat.gcd_done = g_odd && (gy == '0);
  // last quotient bit is formed in the cycle that sees a count of one
  assign stat.div_done = (dcnt == CW'(1));

  // combinational raw result
  logic          s1, s2, so, dsn;
  logic [PW-1:0] t1, t2, mo, nraw, draw;
  logic          nsraw;
  logic signed [2*W+1:0] lhs, rhs;

  always_comb begin
    t1 = PW'(p_anbd);
    t2 = PW'(p_adbn);
    s1 = (ans != bds) && (p_anbd != '0);
    s2 = ((ads != bns) != (op == OP_SUB)) && (p_adbn != '0);
    if (s1 == s2) begin
      so = s1; mo = t1 + t2;
    end else if (t1 >= t2) begin
      so = s1; mo = t1 - t2;
    end else begin
      so = s2; mo = t2 - t1;
    end
    if (mo == '0) so = 1'b0;
    dsn = (ads != bds);
    case (op)
      OP_NEG: begin
        nsraw = !ans && (anm != '0); nraw = PW'(anm); draw = PW'(adm); dsn = ads;
      end
      OP_ADD, OP_SUB: begin
        nsraw = so; nraw = mo; draw = PW'(p_adbd);
      end
      OP_MUL: begin
        nsraw = (ans != bns); nraw = PW'(p_anbn); draw = PW'(p_adbd);
      end
      OP_DIV: begin
        nsraw = (ans != bds); nraw = PW'(p_anbd); draw = PW'(p_adbn);
        dsn = (ads != bns);
      end
      default: begin
        nsraw = ans; nraw = PW'(anm); draw = PW'(adm); dsn = ads;
      end
    endcase
    // compare: sign-corrected cross products
    lhs = (ans != bds) ? -$signed({2'b00, p_anbd}) : $signed({2'b00, p_anbd});
    rhs = (bns != ads) ? -$signed({2'b00, p_adbn}) : $signed({2'b00, p_adbn});
    if (ads != bds) begin
      lhs = -lhs; rhs = -rhs;
    end
  end

  // gcd step: swap-and-subtract on odd values
  logic [PW-1:0] gsx, gsy;
  always_comb begin
    if (gx > gy) begin gsx = gy; gsy = gx - gy; end
    else begin gsx = gx; gsy = gy - gx; end
  end

  // division step: restoring, one bit each for both quotients
  logic [PW:0] trn, trd;
  assign trn = {r_n, q_n[PW-1]} - {1'b0, dvs};
  assign trd = {r_d, q_d[PW-1]} - {1'b0, dvs};

  // final range check
  localparam logic [PW-1:0] TopV = PW'(1) << (W - 1);
  logic          neg, ovf;
  logic [W-1:0]  nlow;
  always_comb begin
    neg  = (ns != ds);
    ovf  = (q_d > TopV - 1'b1) || (neg ? (q_n > TopV) : (q_n > TopV - 1'b1));
    nlow = neg ? W'(~q_n + 1'b1) : W'(q_n);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= op_t'(kind);
      ans     <= a_num[W-1];
      ads     <= a_den[W-1];
      bns     <= b_num[W-1];
      bds     <= b_den[W-1];
      anm     <= magw(a_num[W-1:0]);
      adm     <= magw(a_den[W-1:0]);
      bnm     <= magw(b_num[W-1:0]);
      bdm     <= magw(b_den[W-1:0]);
      ad_zero <= (a_den[W-1:0] == '0);
      bd_zero <= (b_den[W-1:0] == '0);
      mcnt    <= 2'd0;
    end
    if (cmd.mul) begin
      case (mcnt)
        2'd0:    p_anbd <= mprod;
        2'd1:    p_adbn <= mprod;
        2'd2:    p_anbn <= mprod;
        default: p_adbd <= mprod;
      endcase
      mcnt <= mcnt + 2'd1;
    end
    if (cmd.combine) begin
      ns     <= nsraw;
      ds     <= dsn;
      nm     <= nraw;
      dm     <= draw;
      cmp_op <= (op == OP_LESS);
      lt     <= (lhs < rhs);
    end
    if (cmd.gcd_init) begin
      gx    <= nm;
      gy    <= dm;
      gk    <= '0;
      g_odd <= 1'b0;
    end
    if (cmd.gcd_step) begin
      if (!g_odd) begin
        // strip common twos, then make x odd
        if (gx[0] == 1'b0 && gy[0] == 1'b0) begin
          gx <= gx >> 1; gy <= gy >> 1; gk <= gk + 1'b1;
        end else if (gx[0] == 1'b0) begin
          gx <= gx >> 1;
        end else begin
          g_odd <= 1'b1;
        end
      end else if (gy != '0) begin
        if (gy[0] == 1'b0) gy <= gy >> 1;
        else begin gx <= gsx; gy <= gsy; end
      end
    end
    if (cmd.div_init) begin
      dvs  <= gx << gk;
      q_n  <= nm;
      q_d  <= dm;
      r_n  <= '0;
      r_d  <= '0;
      dcnt <= CW'(PW);
    end
    if (cmd.div_step) begin
      if (!trn[PW]) begin r_n <= trn[PW-1:0]; q_n <= {q_n[PW-2:0], 1'b1}; end
      else begin r_n <= {r_n[PW-2:0], q_n[PW-1]}; q_n <= {q_n[PW-2:0], 1'b0}; end
      if (!trd[PW]) begin r_d <= trd[PW-1:0]; q_d <= {q_d[PW-2:0], 1'b1}; end
      else begin r_d <= {r_d[PW-2:0], q_d[PW-1]}; q_d <= {q_d[PW-2:0], 1'b0}; end
      dcnt <= dcnt - 1'b1;
    end
    if (cmd.finish) begin
      is_less <= 1'b0;
      if (cmp_op) begin
        res_num <= '0; res_den <= 31'd1; is_less <= lt;
        status  <= (ad_zero || bd_zero) ? ST_ZDEN : ST_OK;
      end else if (dm == '0) begin
        res_num <= '0; res_den <= '0; status <= ST_ZDEN;
      end else if (nm == '0) begin
        res_num <= '0; res_den <= 31'd1; status <= ST_OK;
      end else if (ovf) begin
        res_num <= '0; res_den <= '0; status <= ST_OVF;
      end else begin
        // numerator is sign-extended to the full port width
        res_num <= 32'($signed(nlow));
        res_den <= 31'(q_d);
        status  <= ST_OK;
      end
    end
  end

endmodule
